// ----- src/swept_box_collision_test_assert.svh -----
// ---------------------------------------------------------------------------
// Swept box collision test assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SWEPT_BOX_COLLISION_TEST_ASSERT_SVH
`define SWEPT_BOX_COLLISION_TEST_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SBC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define SBC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sbc_pkg.sv -----
// ---------------------------------------------------------------------------
// Swept box collision package
// Shared constants and pipeline record types.
// ---------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

   localparam int COORD_BITS_DEF     = 16;
   localparam int TIME_FRAC_BITS_DEF = 16;
   localparam int MOVE_BITS          = 24;
   localparam int MOVE_FRAC          = 8;
   localparam int QUO_BITS           = 24;   // quotient bits below saturation
   localparam int TIME_W             = 27;   // signed time, holds +-2^25
   localparam int LANES              = 4;    // x entry, x exit, y entry, y exit

   localparam int LANE_XE = 0;
   localparam int LANE_XX = 1;
   localparam int LANE_YE = 2;
   localparam int LANE_YX = 3;

   localparam logic signed [TIME_W-1:0] TIME_INF = 27'sd33554432;

   localparam logic signed [1:0] NRM_POS  = 2'sb01;
   localparam logic signed [1:0] NRM_NEG  = 2'sb11;
   localparam logic signed [1:0] NRM_ZERO = 2'sb00;

   typedef struct packed {
      logic [MOVE_BITS-1:0] den;   // |displacement|
      logic [MOVE_BITS-1:0] rem;   // partial remainder
      logic [QUO_BITS-1:0]  quo;   // quotient bits so far
      logic [QUO_BITS-1:0]  numl;  // numerator bits still to shift in
      logic                 sat;   // quotient at or above 2^24
      logic                 neg;   // result sign
   } lane_type;

   typedef struct packed {
      logic zero_x;   // no horizontal motion
      logic zero_y;   // no vertical motion
      logic ien_x;    // x entry distance negative
      logic ien_y;    // y entry distance negative
   } side_type;

endpackage

`default_nettype wire

// ----- src/sbc_setup.sv -----
// ---------------------------------------------------------------------------
// Swept box collision setup stage
// Face distances, signs and divider seeds for the four axis times.
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_setup #(
   parameter int COORD_BITS     = 16,
   parameter int TIME_FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               vld_in,
   input  wire logic signed [COORD_BITS-1:0]       mover_x,
   input  wire logic signed [COORD_BITS-1:0]       mover_y,
   input  wire logic [COORD_BITS-2:0]              mover_w,
   input  wire logic [COORD_BITS-2:0]              mover_h,
   input  wire logic signed [COORD_BITS-1:0]       other_x,
   input  wire logic signed [COORD_BITS-1:0]       other_y,
   input  wire logic [COORD_BITS-2:0]              other_w,
   input  wire logic [COORD_BITS-2:0]              other_h,
   input  wire logic signed [sbc_pkg::MOVE_BITS-1:0] move_x,
   input  wire logic signed [sbc_pkg::MOVE_BITS-1:0] move_y,
   output logic                                    vld_out,
   output sbc_pkg::lane_type [sbc_pkg::LANES-1:0]  lane_out,
   output sbc_pkg::side_type                       side_out
);
   import sbc_pkg::*;

   localparam int DW = COORD_BITS + 2;
   localparam int S  = MOVE_FRAC + TIME_FRAC_BITS;
   localparam int NW = DW + S;
   localparam int NH = NW - QUO_BITS;
   localparam int CW = (NH > MOVE_BITS) ? NH : MOVE_BITS;

   logic                         vld_ff;
   lane_type [LANES-1:0]         lane_ff, lane_in;
   side_type                     side_ff, side_in;

   logic signed [DW-1:0]         de_x, dx_x, de_y, dx_y;
   logic [MOVE_BITS-1:0]         um_x, um_y;

   // seed one lane: sign, magnitude split and saturation test
   function automatic lane_type mk_lane(input logic signed [DW-1:0] d,
                                        input logic mn,
                                        input logic [MOVE_BITS-1:0] um);
      logic [DW-1:0] ud;
      logic [NW-1:0] num;
      logic [NH-1:0] nh;
      lane_type      l;
      ud     = d[DW-1] ? DW'(-d) : DW'(d);
      num    = {ud, S'(0)};
      nh     = num[NW-1:QUO_BITS];
      l.den  = um;
      l.rem  = QUO_BITS'(nh);
      l.quo  = '0;
      l.numl = num[QUO_BITS-1:0];
      l.sat  = CW'(nh) >= CW'(um);
      l.neg  = d[DW-1] ^ mn;
      return l;
   endfunction

   // entry and exit distance on the side the motion faces
   function automatic logic signed [2*DW-1:0] dists(
         input logic signed [COORD_BITS-1:0] mp,
         input logic [COORD_BITS-2:0] ms,
         input logic signed [COORD_BITS-1:0] op,
         input logic [COORD_BITS-2:0] os,
         input logic signed [MOVE_BITS-1:0] mv);
      logic signed [DW-1:0] near, far;
      near = DW'(op) - (DW'(mp) + $signed(DW'(ms)));
      far  = (DW'(op) + $signed(DW'(os))) - DW'(mp);
      return (mv > 0) ? {near, far} : {far, near};
   endfunction

   always_comb begin
      {de_x, dx_x} = dists(mover_x, mover_w, other_x, other_w, move_x);
      {de_y, dx_y} = dists(mover_y, mover_h, other_y, other_h, move_y);
      um_x = move_x[MOVE_BITS-1] ? MOVE_BITS'(-move_x) : MOVE_BITS'(move_x);
      um_y = move_y[MOVE_BITS-1] ? MOVE_BITS'(-move_y) : MOVE_BITS'(move_y);
      lane_in[LANE_XE] = mk_lane(de_x, move_x[MOVE_BITS-1], um_x);
      lane_in[LANE_XX] = mk_lane(dx_x, move_x[MOVE_BITS-1], um_x);
      lane_in[LANE_YE] = mk_lane(de_y, move_y[MOVE_BITS-1], um_y);
      lane_in[LANE_YX] = mk_lane(dx_y, move_y[MOVE_BITS-1], um_y);
      side_in.zero_x   = (move_x == '0);
      side_in.zero_y   = (move_y == '0);
      side_in.ien_x    = de_x[DW-1];
      side_in.ien_y    = de_y[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign lane_out = lane_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

// ----- src/sbc_div_stage.sv -----
// ---------------------------------------------------------------------------
// Swept box collision divider stage
// One restoring division step on all four lanes, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_div_stage #(
   parameter int STEP = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   vld_in,
   input  wire sbc_pkg::lane_type [sbc_pkg::LANES-1:0] lane_in_d,
   input  wire sbc_pkg::side_type                      side_in_d,
   output logic                                        vld_out,
   output sbc_pkg::lane_type [sbc_pkg::LANES-1:0]      lane_out,
   output sbc_pkg::side_type                           side_out
);
   import sbc_pkg::*;

   localparam int BIT = QUO_BITS - 1 - STEP;

   logic                 vld_ff;
   lane_type [LANES-1:0] lane_ff, lane_in;
   side_type             side_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [MOVE_BITS:0] t;
         logic [MOVE_BITS:0] diff;
         logic               ge;
         t    = {lane_in_d[i].rem, lane_in_d[i].numl[BIT]};
         diff = t - {1'b0, lane_in_d[i].den};
         ge   = t >= {1'b0, lane_in_d[i].den};
         lane_in[i]     = lane_in_d[i];
         lane_in[i].rem = ge ? diff[MOVE_BITS-1:0] : t[MOVE_BITS-1:0];
         lane_in[i].quo = {lane_in_d[i].quo[QUO_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= side_in_d;
      end
   end

   assign vld_out  = vld_ff;
   assign lane_out = lane_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

// ----- src/sbc_resolve.sv -----
// ---------------------------------------------------------------------------
// Swept box collision resolve stages
// Signed axis times, then hit decision, entry time and face normal.
// ---------------------------------------------------------------------------
`default_nettype none

module sbc_resolve #(
   parameter int TIME_FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   vld_in,
   input  wire sbc_pkg::lane_type [sbc_pkg::LANES-1:0] lane_in_d,
   input  wire sbc_pkg::side_type                      side_in_d,
   output logic                                        vld_out,
   output logic                                        hit,
   output logic [TIME_FRAC_BITS:0]                     entry_time,
   output logic signed [1:0]                           normal_x,
   output logic signed [1:0]                           normal_y
);
   import sbc_pkg::*;

   localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(2 ** TIME_FRAC_BITS);

   logic                               vld_a_ff, vld_b_ff;
   logic signed [TIME_W-1:0]           tm_ff [LANES];
   logic signed [TIME_W-1:0]           tm_in [LANES];
   side_type                           side_ff;
   logic                               hit_ff, hit_in;
   logic [TIME_FRAC_BITS:0]            et_ff, et_in;
   logic signed [1:0]                  nx_ff, nx_in, ny_ff, ny_in;
   logic signed [TIME_W-1:0]           t_entry, t_leave;

   // stage A: apply saturation, sign and the no-motion infinities
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [QUO_BITS:0]        mag;
         logic signed [TIME_W-1:0] sm;
         logic                     zero;
         mag  = lane_in_d[i].sat ? {1'b1, QUO_BITS'(0)} : {1'b0, lane_in_d[i].quo};
         sm   = $signed(TIME_W'(mag));
         zero = (i < LANE_YE) ? side_in_d.zero_x : side_in_d.zero_y;
         if (zero) begin
            tm_in[i] = (i == LANE_XE || i == LANE_YE) ? -TIME_INF : TIME_INF;
         end else begin
            tm_in[i] = lane_in_d[i].neg ? -sm : sm;
         end
      end
   end

   // stage B: latest entry, earliest exit, decide
   always_comb begin
      t_entry = (tm_ff[LANE_XE] > tm_ff[LANE_YE]) ? tm_ff[LANE_XE] : tm_ff[LANE_YE];
      t_leave = (tm_ff[LANE_XX] < tm_ff[LANE_YX]) ? tm_ff[LANE_XX] : tm_ff[LANE_YX];
      hit_in  = !((t_entry > t_leave)
                  || (tm_ff[LANE_XE] < 0 && tm_ff[LANE_YE] < 0)
                  || (tm_ff[LANE_XE] > T_ONE) || (tm_ff[LANE_YE] > T_ONE));
      nx_in   = NRM_ZERO;
      ny_in   = NRM_ZERO;
      et_in   = T_ONE[TIME_FRAC_BITS:0];
      if (hit_in) begin
         et_in = t_entry[TIME_FRAC_BITS:0];
         if (tm_ff[LANE_XE] > tm_ff[LANE_YE]) begin
            nx_in = side_ff.ien_x ? NRM_POS : NRM_NEG;
         end else begin
            ny_in = side_ff.ien_y ? NRM_POS : NRM_NEG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= vld_in;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tm_ff   <= tm_in;
         side_ff <= side_in_d;
         hit_ff  <= hit_in;
         et_ff   <= et_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
      end
   end

   assign vld_out    = vld_b_ff;
   assign hit        = hit_ff;
   assign entry_time = et_ff;
   assign normal_x   = nx_ff;
   assign normal_y   = ny_ff;

endmodule

`default_nettype wire

// ----- src/swept_box_collision_test.sv -----
// ---------------------------------------------------------------------------
// Swept box collision test
// Swept axis-aligned box test, one box pair per transfer, fully pipelined.
// ---------------------------------------------------------------------------
// Each req transfer carries a moving box, its displacement for one step and
// an obstacle box; each produces exactly one rsp transfer, in order, telling
// whether the boxes touch within the step, the entry time as an unsigned
// fraction with TIME_FRAC_BITS fraction bits (1.0 when there is no hit) and
// the unit normal of the struck face. The block takes a new pair every clock
// cycle and holds that rate indefinitely while rsp_tready stays high; a
// result passes through one setup stage, then a 24-stage
// restoring divider that produces one quotient bit per stage for all four
// axis times in parallel, and two resolve stages. While a result waits with
// rsp_tready low the whole pipeline holds, and req_tready drops with it. The
// block keeps no state between pairs and has no configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_test #(
   parameter int COORD_BITS     = sbc_pkg::COORD_BITS_DEF,
   parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF,
   parameter int REQ_W = ((8 * COORD_BITS + 44 + 7) / 8) * 8,
   parameter int RSP_W = ((TIME_FRAC_BITS + 6 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // mover_x, mover_y, mover_w, mover_h, other_x, other_y, other_w, other_h,
   // move_x, move_y (lowest bit up), zero pad to whole bytes
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // hit, entry_time, normal_x, normal_y (lowest bit up), zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready
);
   import sbc_pkg::*;

   // field offsets in req_tdata
   localparam int O_MX = 0;
   localparam int O_MY = COORD_BITS;
   localparam int O_MW = 2 * COORD_BITS;
   localparam int O_MH = 3 * COORD_BITS - 1;
   localparam int O_OX = 4 * COORD_BITS - 2;
   localparam int O_OY = 5 * COORD_BITS - 2;
   localparam int O_OW = 6 * COORD_BITS - 2;
   localparam int O_OH = 7 * COORD_BITS - 3;
   localparam int O_VX = 8 * COORD_BITS - 4;
   localparam int O_VY = O_VX + MOVE_BITS;

   logic                 en;
   logic                 pipe_vld  [QUO_BITS+1];
   lane_type [LANES-1:0] pipe_lane [QUO_BITS+1];
   side_type             pipe_side [QUO_BITS+1];

   logic                          res_hit;
   logic [TIME_FRAC_BITS:0]       res_et;
   logic signed [1:0]             res_nx, res_ny;

   // advance everything unless a finished result is stuck at the output
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   sbc_setup #(
      .COORD_BITS     (COORD_BITS),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_setup (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (req_tvalid),
      .mover_x  ($signed(req_tdata[O_MX +: COORD_BITS])),
      .mover_y  ($signed(req_tdata[O_MY +: COORD_BITS])),
      .mover_w  (req_tdata[O_MW +: COORD_BITS-1]),
      .mover_h  (req_tdata[O_MH +: COORD_BITS-1]),
      .other_x  ($signed(req_tdata[O_OX +: COORD_BITS])),
      .other_y  ($signed(req_tdata[O_OY +: COORD_BITS])),
      .other_w  (req_tdata[O_OW +: COORD_BITS-1]),
      .other_h  (req_tdata[O_OH +: COORD_BITS-1]),
      .move_x   ($signed(req_tdata[O_VX +: MOVE_BITS])),
      .move_y   ($signed(req_tdata[O_VY +: MOVE_BITS])),
      .vld_out  (pipe_vld[0]),
      .lane_out (pipe_lane[0]),
      .side_out (pipe_side[0])
   );

   // divider: one quotient bit per stage, most significant first
   for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
      sbc_div_stage #(
         .STEP (s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .vld_in    (pipe_vld[s]),
         .lane_in_d (pipe_lane[s]),
         .side_in_d (pipe_side[s]),
         .vld_out   (pipe_vld[s+1]),
         .lane_out  (pipe_lane[s+1]),
         .side_out  (pipe_side[s+1])
      );
   end

   sbc_resolve #(
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_resolve (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .vld_in     (pipe_vld[QUO_BITS]),
      .lane_in_d  (pipe_lane[QUO_BITS]),
      .side_in_d  (pipe_side[QUO_BITS]),
      .vld_out    (rsp_tvalid),
      .hit        (res_hit),
      .entry_time (res_et),
      .normal_x   (res_nx),
      .normal_y   (res_ny)
   );

   // pack the result, pad high bits with zeros
   assign rsp_tdata = RSP_W'({res_ny, res_nx, res_et, res_hit});

endmodule

`default_nettype wire

// ----- src/sbc_checker.sv -----
// ---------------------------------------------------------------------------
// Swept box collision port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "swept_box_collision_test_assert.svh"

module sbc_checker #(
   parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF,
   parameter int RSP_W = ((TIME_FRAC_BITS + 6 + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready
);
   localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS+1)'(2 ** TIME_FRAC_BITS);

   logic                    c_hit;
   logic [TIME_FRAC_BITS:0] c_et;
   logic [1:0]              c_nx, c_ny;

   assign c_hit = rsp_tdata[0];
   assign c_et  = rsp_tdata[1 +: TIME_FRAC_BITS+1];
   assign c_nx  = rsp_tdata[TIME_FRAC_BITS+2 +: 2];
   assign c_ny  = rsp_tdata[TIME_FRAC_BITS+4 +: 2];

   `SBC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `SBC_ASSERT_IMP(a_miss_form, clock, reset, rsp_tvalid && !c_hit, c_et == ONE && c_nx == 2'b00 && c_ny == 2'b00, "miss result not canonical")
   `SBC_ASSERT_IMP(a_hit_form, clock, reset, rsp_tvalid && c_hit, ((c_nx == 2'b00) != (c_ny == 2'b00)) && c_et <= ONE && c_nx != 2'b10 && c_ny != 2'b10, "hit result malformed")
   `SBC_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), !rsp_tvalid, "result valid right after reset")

endmodule

bind swept_box_collision_test sbc_checker #(
   .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_sbc_checker (.*);

`default_nettype wire
